[src/mjd2cal_pkg.sv]
package mjd2cal_pkg;

  // field widths
  localparam int unsigned DAY_W     = 23;
  localparam int unsigned DAYFRAC_W = 32;
  localparam int unsigned YEAR_W    = 15;
  localparam int unsigned MONTH_W   = 4;
  localparam int unsigned MDAY_W    = 5;
  localparam int unsigned WDAY_W    = 3;
  localparam int unsigned HOUR_W    = 5;
  localparam int unsigned MINUTE_W  = 6;
  localparam int unsigned SECOND_W  = 6;

  typedef struct packed {
    logic signed [DAY_W-1:0]     day_number;
    logic        [DAYFRAC_W-1:0] day_fraction;
  } request_t;

  typedef struct packed {
    logic signed [YEAR_W-1:0]  year;
    logic        [MONTH_W-1:0] month;
    logic        [MDAY_W-1:0]  day_of_month;
    logic        [WDAY_W-1:0]  weekday;
    logic        [HOUR_W-1:0]  hour;
    logic        [MINUTE_W-1:0] minute;
    logic        [SECOND_W-1:0] second;
  } result_t;

  // first Gregorian day, 1582-10-15
  localparam int GREGORIAN_START = -100840;
  localparam int JD_JULIAN       = 2401525;
  localparam int JD_GREG         = 2401526;
  localparam int YEAR_BASE       = 4715;
  localparam int DAYS_PER_YEAR   = 365;
  localparam int MARCH           = 3;
  localparam int FIRST_JAN_CODE  = 14;
  localparam int MONTH_ADJ_LOW   = 1;
  localparam int MONTH_ADJ_HIGH  = 13;

  // Exact floor division by a constant: q = (n * ceil(2^s / D)) >> s,
  // with s = bits(n) + bits(D). Signed numerators are biased by K*D first.

  // century term: floor((4d + 2131139) / 146097), numerator biased to 26 bits
  localparam int unsigned B_NUM_W  = 26;
  localparam int unsigned B_Q_W    = 8;
  localparam int unsigned B_SHIFT  = 44;
  localparam int          B_DIV    = 146097;
  localparam int          B_OFFSET = 101;
  localparam int          B_ADD    = 2131139 + B_OFFSET * B_DIV;
  localparam logic [26:0] B_RECIP  =
    27'(((64'd1 << B_SHIFT) + 64'(B_DIV) - 64'd1) / 64'(B_DIV));

  // year term: floor((20c - 2442) / 7305), numerator biased to 28 bits
  localparam int unsigned C_W      = 24;
  localparam int unsigned A_NUM_W  = 28;
  localparam int unsigned A_Q_W    = 16;
  localparam int unsigned A_SHIFT  = 41;
  localparam int          A_DIV    = 7305;
  localparam int          A_OFFSET = 4909;
  localparam int          A_ADD    = A_OFFSET * A_DIV - 2442;
  localparam logic [28:0] A_RECIP  =
    29'(((64'd1 << A_SHIFT) + 64'(A_DIV) - 64'd1) / 64'(A_DIV));

  // month term: floor(10000 r / 306001), the 10000 folded into the constant
  localparam int unsigned R_W      = 9;
  localparam int unsigned F_W      = 4;
  localparam int unsigned F_SHIFT  = 42;
  localparam int          F_DIV    = 306001;
  localparam int          F_MUL    = 10000;
  localparam logic [37:0] F_RECIP  =
    38'(64'(F_MUL) * (((64'd1 << F_SHIFT) + 64'(F_DIV) - 64'd1) / 64'(F_DIV)));

  // weekday: (d + 3) mod 7, biased to 24 bits
  localparam int unsigned W_NUM_W  = 24;
  localparam int unsigned W_SHIFT  = 27;
  localparam int          W_DIV    = 7;
  localparam int          W_ADD    = 3 + 599186 * W_DIV;
  localparam logic [24:0] W_RECIP  =
    25'(((64'd1 << W_SHIFT) + 64'(W_DIV) - 64'd1) / 64'(W_DIV));

  // seconds of day: 86400 = 675 * 2^7
  localparam int unsigned SECS_W        = 17;
  localparam int          SEC_SCALE     = 675;
  localparam int unsigned SEC_SCALE_W   = 10;
  localparam int unsigned SEC_POW2      = 7;
  localparam int unsigned SEC_REM_W     = 12;
  localparam int          SECS_PER_HOUR = 3600;
  localparam int          SECS_PER_MIN  = 60;
  localparam int unsigned H_SHIFT       = 29;
  localparam logic [17:0] H_RECIP       =
    18'(((64'd1 << H_SHIFT) + 64'(SECS_PER_HOUR) - 64'd1) / 64'(SECS_PER_HOUR));
  localparam int unsigned M_SHIFT       = 18;
  localparam logic [12:0] M_RECIP       =
    13'(((64'd1 << M_SHIFT) + 64'(SECS_PER_MIN) - 64'd1) / 64'(SECS_PER_MIN));

  // floor(30.6001 * f): day count before month code f
  function automatic logic [R_W-1:0] month_offset(input logic [F_W-1:0] f);
    logic [R_W-1:0] v;
    unique case (f)
      4'd0:    v = 9'd0;
      4'd1:    v = 9'd30;
      4'd2:    v = 9'd61;
      4'd3:    v = 9'd91;
      4'd4:    v = 9'd122;
      4'd5:    v = 9'd153;
      4'd6:    v = 9'd183;
      4'd7:    v = 9'd214;
      4'd8:    v = 9'd244;
      4'd9:    v = 9'd275;
      4'd10:   v = 9'd306;
      4'd11:   v = 9'd336;
      4'd12:   v = 9'd367;
      4'd13:   v = 9'd397;
      4'd14:   v = 9'd428;
      4'd15:   v = 9'd459;
      default: v = 9'd0;
    endcase
    return v;
  endfunction

endpackage

[src/mjd_to_calendar_date_core.sv]
// Channel  | Ports                    | Handshake
// ---------+--------------------------+------------------------------------------
// request  | start, busy, request     | taken at a clock edge with start & !busy
// result   | done, result             | done high one cycle; always taken
//
// Six-stage pipeline: each request runs through stages 1 to 6 to the result,
// one request per clock, back to back. The depth is set by the chain of
// three reciprocal multiplies in the date path (century, year, month term).
// rst (synchronous, active high) clears the valid bits; busy is high only in
// reset. The result side cannot stall, so the pipeline never holds.
module mjd_to_calendar_date_core #(
  parameter int unsigned FRACTION_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  mjd2cal_pkg::request_t request,
  output logic                  done,
  output mjd2cal_pkg::result_t  result
);
  import mjd2cal_pkg::*;

  localparam int unsigned LATENCY    = 6;
  // fraction bits that carry weight, and the product frac * 675
  localparam int unsigned FRAC_W     =
    (FRACTION_BITS < DAYFRAC_W) ? FRACTION_BITS : DAYFRAC_W;
  localparam int unsigned SEC_PROD_W = FRAC_W + SEC_SCALE_W;
  localparam int unsigned SEC_SHIFT  = FRACTION_BITS - SEC_POW2;

  assign busy = rst;

  // valid bits, one per stage
  logic v1, v2, v3, v4, v5;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1   <= 1'b0;
      v2   <= 1'b0;
      v3   <= 1'b0;
      v4   <= 1'b0;
      v5   <= 1'b0;
      done <= 1'b0;
    end else begin
      v1   <= start && !busy;
      v2   <= v1;
      v3   <= v2;
      v4   <= v3;
      v5   <= v4;
      done <= v5;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 1: century term, julian select, weekday, seconds of day
  // ---------------------------------------------------------------------
  logic signed [B_NUM_W:0]         b_num_s;
  logic [B_NUM_W-1:0]              b_num;
  logic [B_NUM_W+26:0]             b_prod;
  logic [B_Q_W-1:0]                b_quo;
  logic signed [B_Q_W+1:0]         b_wide;
  logic [W_NUM_W-1:0]              w_num;
  logic [W_NUM_W+24:0]             w_prod;
  logic [WDAY_W-1:0]               w_quo;
  logic [FRAC_W-1:0]               frac_in;
  logic [SEC_PROD_W-1:0]           sec_prod;
  logic [SEC_PROD_W-1:0]           sec_shifted;

  always_comb begin
    // floor((4d + 2131139) / 146097), biased nonnegative
    b_num_s = ((B_NUM_W+1)'(request.day_number) <<< 2) + (B_NUM_W+1)'(B_ADD);
    b_num   = b_num_s[B_NUM_W-1:0];
    b_prod  = (B_NUM_W+27)'(b_num) * (B_NUM_W+27)'(B_RECIP);
    b_quo   = b_prod[B_SHIFT +: B_Q_W];
    b_wide  = $signed({2'b00, b_quo}) - (B_Q_W+2)'(B_OFFSET);
    // n mod 7 = (n - 7q) mod 8 = n + q mod 8
    w_num   = W_NUM_W'(request.day_number) + W_NUM_W'(W_ADD);
    w_prod  = (W_NUM_W+25)'(w_num) * (W_NUM_W+25)'(W_RECIP);
    w_quo   = w_prod[W_SHIFT +: WDAY_W];
    // elapsed seconds, truncated
    frac_in     = request.day_fraction[FRAC_W-1:0];
    sec_prod    = SEC_PROD_W'(frac_in) * SEC_PROD_W'(SEC_SCALE);
    sec_shifted = sec_prod >> SEC_SHIFT;
  end

  logic signed [DAY_W-1:0] d1;
  logic signed [B_Q_W:0]   b1;
  logic                    jul1;
  logic [WDAY_W-1:0]       wday1;
  logic [SECS_W-1:0]       secs1;

  always_ff @(posedge clk) begin
    d1    <= request.day_number;
    b1    <= b_wide[B_Q_W:0];
    jul1  <= request.day_number < DAY_W'(GREGORIAN_START);
    wday1 <= w_num[WDAY_W-1:0] + w_quo;
    secs1 <= sec_shifted[SECS_W-1:0];
  end

  // ---------------------------------------------------------------------
  // Stage 2: julian day count c, hour
  // ---------------------------------------------------------------------
  logic signed [C_W-1:0] c_next;
  logic [SECS_W+17:0]    h_prod;

  always_comb begin
    if (jul1) begin
      c_next = C_W'(d1) + C_W'(JD_JULIAN);
    end else begin
      c_next = C_W'(d1) + C_W'(JD_GREG) + C_W'(b1) - C_W'(b1 >>> 2);
    end
    h_prod = (SECS_W+18)'(secs1) * (SECS_W+18)'(H_RECIP);
  end

  logic signed [C_W-1:0] c2;
  logic [WDAY_W-1:0]     wday2;
  logic [SECS_W-1:0]     secs2;
  logic [HOUR_W-1:0]     hour2;

  always_ff @(posedge clk) begin
    c2    <= c_next;
    wday2 <= wday1;
    secs2 <= secs1;
    hour2 <= h_prod[H_SHIFT +: HOUR_W];
  end

  // ---------------------------------------------------------------------
  // Stage 3: year term a, seconds left in hour
  // ---------------------------------------------------------------------
  logic signed [A_NUM_W+1:0] a_num_s;
  logic [A_NUM_W-1:0]        a_num;
  logic [A_NUM_W+28:0]       a_prod;
  logic [A_Q_W-1:0]          a_quo;
  logic signed [A_Q_W:0]     a_wide;
  logic [SECS_W-1:0]         rem_wide;

  always_comb begin
    // 20c = 16c + 4c
    a_num_s  = ((A_NUM_W+2)'(c2) <<< 4) + ((A_NUM_W+2)'(c2) <<< 2)
             + (A_NUM_W+2)'(A_ADD);
    a_num    = a_num_s[A_NUM_W-1:0];
    a_prod   = (A_NUM_W+29)'(a_num) * (A_NUM_W+29)'(A_RECIP);
    a_quo    = a_prod[A_SHIFT +: A_Q_W];
    a_wide   = $signed({1'b0, a_quo}) - (A_Q_W+1)'(A_OFFSET);
    rem_wide = secs2 - SECS_W'(hour2) * SECS_W'(SECS_PER_HOUR);
  end

  logic signed [C_W-1:0]   c3;
  logic signed [A_Q_W-1:0] a3;
  logic [WDAY_W-1:0]       wday3;
  logic [HOUR_W-1:0]       hour3;
  logic [SEC_REM_W-1:0]    rem3;

  always_ff @(posedge clk) begin
    c3    <= c2;
    a3    <= a_wide[A_Q_W-1:0];
    wday3 <= wday2;
    hour3 <= hour2;
    rem3  <= rem_wide[SEC_REM_W-1:0];
  end

  // ---------------------------------------------------------------------
  // Stage 4: day within shifted year r, minute
  // ---------------------------------------------------------------------
  logic signed [C_W:0]      e_val;
  logic signed [C_W:0]      r_wide;
  logic [SEC_REM_W+12:0]    m_prod;

  always_comb begin
    // e = floor(365.25 a)
    e_val  = (C_W+1)'(a3) * (C_W+1)'(DAYS_PER_YEAR) + (C_W+1)'(a3 >>> 2);
    r_wide = (C_W+1)'(c3) - e_val;
    m_prod = (SEC_REM_W+13)'(rem3) * (SEC_REM_W+13)'(M_RECIP);
  end

  logic signed [A_Q_W-1:0] a4;
  logic [R_W-1:0]          r4;
  logic [WDAY_W-1:0]       wday4;
  logic [HOUR_W-1:0]       hour4;
  logic [MINUTE_W-1:0]     min4;
  logic [SEC_REM_W-1:0]    rem4;

  always_ff @(posedge clk) begin
    a4    <= a3;
    r4    <= r_wide[R_W-1:0];
    wday4 <= wday3;
    hour4 <= hour3;
    min4  <= m_prod[M_SHIFT +: MINUTE_W];
    rem4  <= rem3;
  end

  // ---------------------------------------------------------------------
  // Stage 5: month code f, second
  // ---------------------------------------------------------------------
  logic [R_W+37:0]       f_prod;
  logic [SEC_REM_W-1:0]  sec_wide;

  always_comb begin
    f_prod   = (R_W+38)'(r4) * (R_W+38)'(F_RECIP);
    sec_wide = rem4 - SEC_REM_W'(min4) * SEC_REM_W'(SECS_PER_MIN);
  end

  logic signed [A_Q_W-1:0] a5;
  logic [R_W-1:0]          r5;
  logic [F_W-1:0]          f5;
  logic [WDAY_W-1:0]       wday5;
  logic [HOUR_W-1:0]       hour5;
  logic [MINUTE_W-1:0]     min5;
  logic [SECOND_W-1:0]     sec5;

  always_ff @(posedge clk) begin
    a5    <= a4;
    r5    <= r4;
    f5    <= f_prod[F_SHIFT +: F_W];
    wday5 <= wday4;
    hour5 <= hour4;
    min5  <= min4;
    sec5  <= sec_wide[SECOND_W-1:0];
  end

  // ---------------------------------------------------------------------
  // Stage 6: month, day of month, year into the output register
  // ---------------------------------------------------------------------
  logic [MONTH_W-1:0]       mon_next;
  logic                     past_feb;
  logic [R_W-1:0]           mday_wide;
  logic signed [A_Q_W:0]    year_wide;
  result_t                  result_next;

  always_comb begin
    // codes 14 and 15 are January and February of the following year
    if (f5 >= F_W'(FIRST_JAN_CODE)) begin
      mon_next = F_W'(f5 - F_W'(MONTH_ADJ_HIGH));
    end else begin
      mon_next = F_W'(f5 - F_W'(MONTH_ADJ_LOW));
    end
    past_feb  = mon_next >= MONTH_W'(MARCH);
    mday_wide = r5 - month_offset(f5);
    year_wide = (A_Q_W+1)'(a5) - (A_Q_W+1)'(YEAR_BASE) - (A_Q_W+1)'(past_feb);

    result_next.year         = year_wide[YEAR_W-1:0];
    result_next.month        = mon_next;
    result_next.day_of_month = mday_wide[MDAY_W-1:0];
    result_next.weekday      = wday5;
    result_next.hour         = hour5;
    result_next.minute       = min5;
    result_next.second       = sec5;
  end

  always_ff @(posedge clk) begin
    result <= result_next;
  end

  // ---------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##LATENCY done)
    else $error("request did not come out after the pipeline depth");

  a_date_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (result.month >= MONTH_W'(1) && result.month <= MONTH_W'(12) &&
              result.day_of_month >= MDAY_W'(1) && result.weekday <= WDAY_W'(6)))
    else $error("calendar field out of range");

  a_clock_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (result.hour <= HOUR_W'(23) && result.minute <= MINUTE_W'(59) &&
              result.second <= SECOND_W'(59)))
    else $error("time of day field out of range");

endmodule
